// ----- rtl/text_console_writer_core_defines.svh -----
// Assertion macros for the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
// Shared constants, types and helper functions of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int TAB_ADVANCE = 4;
	localparam int CELLS       = ROWS * COLUMNS;
	localparam int ADDR_W      = $clog2(CELLS);
	localparam int ROW_W       = 5;
	localparam int COL_W       = 7;
	localparam int CELL_W      = 16;
	localparam int TAB_WRAP    = (TAB_ADVANCE < COLUMNS) ? TAB_ADVANCE : (COLUMNS - 1);

	localparam logic [1:0] MODE_PUT_CHAR = 2'd0;
	localparam logic [1:0] MODE_PUT_CELL = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;
	localparam logic [1:0] MODE_READ     = 2'd3;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_TAB     = 8'd9;
	localparam logic [7:0] CODE_SPACE   = 8'd32;
	localparam logic [7:0] TEXT_COLOR_RESET = 8'd7;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CELL_W-1:0] cell_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [7:0]       char_code;
		logic [7:0]       cell_color;
		logic [COL_W-1:0] cell_col;
		logic [ROW_W-1:0] cell_row;
	} item_t;

	typedef struct packed {
		logic [ROW_W-1:0] cursor_row;
		logic [COL_W-1:0] cursor_col;
		logic             scrolled;
		cell_t            cell_value;
	} result_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		cell_t wdata;
		logic  re;
		addr_t raddr;
	} ram_req_t;

	function automatic addr_t cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		int lin;
		lin = int'(row) * COLUMNS + int'(col);
		return addr_t'(lin);
	endfunction

	function automatic logic in_screen(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return (int'(row) < ROWS) && (int'(col) < COLUMNS);
	endfunction

endpackage

// ----- rtl/tcw_ram.sv -----
// Simple dual-port synchronous RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module tcw_ram #(
	parameter int DEPTH  = 2000,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/tcw_ctrl.sv -----
// Command sequencer: cursor state, screen sweeps and the screen store access schedule.
`timescale 1ns / 1ps
module tcw_ctrl import tcw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  item_t    item,
	input  logic [7:0] text_color,
	output ram_req_t ram_req,
	input  cell_t    ram_rdata,
	input  logic     out_free,
	output logic     res_valid,
	output result_t  res
);

`include "text_console_writer_core_defines.svh"

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_SCROLL = 3'd2;
	localparam logic [2:0] ST_BLANK  = 3'd3;
	localparam logic [2:0] ST_CLEAR  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	localparam addr_t LAST_COPY  = addr_t'(CELLS - COLUMNS - 1);
	localparam addr_t BOTTOM_ROW = addr_t'(CELLS - COLUMNS);
	localparam addr_t LAST_CELL  = addr_t'(CELLS - 1);

	logic [2:0]       state_q;
	addr_t            idx_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [COL_W-1:0] cur_col_q;
	logic             scrolled_q;
	cell_t            value_q;

	// Write stage: every store write is registered here and issued in the cycle after it is scheduled.
	logic  we_s1;
	logic  from_ram_s1;
	addr_t waddr_s1;
	cell_t wdata_s1;

	logic             accept;
	logic             pos_ok;
	addr_t            item_addr;
	cell_t            blank;
	logic [COL_W:0]   col_inc;
	logic [COL_W:0]   tab_sum;
	logic [ROW_W:0]   row_inc;
	logic             row_adv;
	logic             need_scroll;
	logic [ROW_W-1:0] nxt_row;
	logic [COL_W-1:0] nxt_col;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign pos_ok     = in_screen(item.cell_row, item.cell_col);
	assign item_addr  = cell_addr(item.cell_row, item.cell_col);
	assign blank      = {text_color, CODE_SPACE};
	assign col_inc    = {1'b0, cur_col_q} + (COL_W+1)'(1);
	assign tab_sum    = {1'b0, cur_col_q} + (COL_W+1)'(TAB_ADVANCE + 1);
	assign row_inc    = {1'b0, cur_row_q} + (ROW_W+1)'(1);

	always_comb begin
		row_adv = 1'b0;
		nxt_col = cur_col_q;
		if (item.char_code == CODE_NEWLINE) begin
			row_adv = 1'b1;
			nxt_col = '0;
		end else if (item.char_code == CODE_TAB) begin
			if (tab_sum >= (COL_W+1)'(COLUMNS)) begin
				row_adv = 1'b1;
				nxt_col = COL_W'(TAB_WRAP);
			end else begin
				nxt_col = tab_sum[COL_W-1:0];
			end
		end else begin
			if (col_inc >= (COL_W+1)'(COLUMNS)) begin
				row_adv = 1'b1;
				nxt_col = '0;
			end else begin
				nxt_col = col_inc[COL_W-1:0];
			end
		end
		need_scroll = row_adv && (row_inc >= (ROW_W+1)'(ROWS));
		if (!row_adv) begin
			nxt_row = cur_row_q;
		end else if (need_scroll) begin
			nxt_row = ROW_W'(ROWS - 1);
		end else begin
			nxt_row = row_inc[ROW_W-1:0];
		end
	end

	always_comb begin
		ram_req.we    = we_s1;
		ram_req.waddr = waddr_s1;
		ram_req.wdata = from_ram_s1 ? ram_rdata : wdata_s1;
		ram_req.re    = 1'b0;
		ram_req.raddr = item_addr;
		if (state_q == ST_SCROLL) begin
			ram_req.re    = 1'b1;
			ram_req.raddr = idx_q + addr_t'(COLUMNS);
		end else if (accept && item.mode == MODE_READ && pos_ok) begin
			ram_req.re = 1'b1;
		end
	end

	assign res_valid = (state_q == ST_DONE) && out_free;
	assign res       = '{cursor_row: cur_row_q, cursor_col: cur_col_q,
			scrolled: scrolled_q, cell_value: value_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			scrolled_q  <= 1'b0;
			value_q     <= '0;
			we_s1       <= 1'b0;
			from_ram_s1 <= 1'b0;
			waddr_s1    <= '0;
			wdata_s1    <= '0;
		end else begin
			we_s1       <= 1'b0;
			from_ram_s1 <= 1'b0;
			unique case (state_q) inside
				ST_IDLE: begin
					if (accept) begin
						scrolled_q <= 1'b0;
						value_q    <= '0;
						state_q    <= ST_DONE;
						unique case (item.mode)
							MODE_PUT_CHAR: begin
								if (item.char_code != CODE_NEWLINE &&
										item.char_code != CODE_TAB) begin
									we_s1    <= 1'b1;
									waddr_s1 <= cell_addr(cur_row_q, cur_col_q);
									wdata_s1 <= {text_color, item.char_code};
								end
								cur_row_q  <= nxt_row;
								cur_col_q  <= nxt_col;
								scrolled_q <= need_scroll;
								if (need_scroll) begin
									idx_q   <= '0;
									state_q <= ST_SCROLL;
								end
							end
							MODE_PUT_CELL: begin
								we_s1    <= pos_ok;
								waddr_s1 <= item_addr;
								wdata_s1 <= {item.cell_color, item.char_code};
							end
							MODE_CLEAR: begin
								cur_row_q <= '0;
								cur_col_q <= '0;
								idx_q     <= '0;
								state_q   <= ST_CLEAR;
							end
							MODE_READ: begin
								if (pos_ok) begin
									state_q <= ST_READ;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_READ: begin
					value_q <= ram_rdata;
					state_q <= ST_DONE;
				end
				ST_SCROLL: begin
					we_s1       <= 1'b1;
					from_ram_s1 <= 1'b1;
					waddr_s1    <= idx_q;
					if (idx_q == LAST_COPY) begin
						idx_q   <= BOTTOM_ROW;
						state_q <= ST_BLANK;
					end else begin
						idx_q <= idx_q + addr_t'(1);
					end
				end
				ST_BLANK, ST_CLEAR: begin
					we_s1    <= 1'b1;
					waddr_s1 <= idx_q;
					wdata_s1 <= blank;
					if (idx_q == LAST_CELL) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + addr_t'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TCW_ASSERT_NOW(a_cursor_on_screen, 1'b1,
		(int'(cur_row_q) < ROWS) && (int'(cur_col_q) < COLUMNS), "cursor left the screen")
	`TCW_ASSERT_NOW(a_write_in_store, we_s1, int'(waddr_s1) < CELLS,
		"store write beyond the last cell")
	`TCW_ASSERT_NEXT(a_scroll_copies, state_q == ST_SCROLL, we_s1 && from_ram_s1,
		"scroll cycle did not schedule a row copy write")
	`TCW_ASSERT_NEXT(a_result_frees, res_valid, state_q == ST_IDLE,
		"sequencer did not return to idle after handing over a result")

endmodule

// ----- rtl/text_console_writer_core.sv -----
// Top level of the text console writer: stream ports, colour register and result register.
`timescale 1ns / 1ps
// Text-mode console engine over a 25 x 80 screen of 16-bit cells (attribute byte above the
// character byte), held in one synchronous RAM with a registered read port. Each input
// transfer carries a command in s_tuser and yields exactly one result transfer holding the
// cursor position, a scroll flag and, for reads, the cell read. Commands run one at a time;
// s_tready is high only while the sequencer is idle, and a finished result sits in the
// output register so that the next command may be taken while it waits. A plain character,
// newline, tab without scroll, or a cell write goes straight from idle to the done state; an
// on-screen cell read passes through a read state for the RAM's registered read port. A clear
// sweeps every cell through the single write port. A stream command that runs off the
// bottom row scrolls: rows are copied up one cell a cycle (read one row below, write back
// in the next cycle), then the bottom row is blanked. The screen store is not cleared by
// reset; its content is undefined until the first clear, and no clearing pass follows reset.
// The colour register text_color (reset 7) is written through the cfg channel, which is
// always ready, and must only be written while no command is outstanding.
module text_console_writer_core import tcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel: text_color.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// Command stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // char_code[7:0], cell_color[15:8], cell_col[22:16],
	                              // cell_row[27:23], zero[31:28]
	input  logic [1:0]  s_tuser,  // mode[1:0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // cursor_row[4:0], cursor_col[11:5], scrolled[12],
	                              // cell_value[28:13], zero[31:29]
);

	logic [7:0] text_color_q;
	logic       m_tvalid_q;
	logic [31:0] m_tdata_q;

	item_t    item;
	ram_req_t ram_req;
	cell_t    ram_rdata;
	logic     out_free;
	logic     res_valid;
	result_t  res;

	// The colour register takes a transfer in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= TEXT_COLOR_RESET;
		end else if (cfg_valid) begin
			text_color_q <= cfg_data;
		end
	end

	// Unpack the command fields from the stream.
	assign item.mode       = s_tuser;
	assign item.char_code  = s_tdata[7:0];
	assign item.cell_color = s_tdata[15:8];
	assign item.cell_col   = s_tdata[22:16];
	assign item.cell_row   = s_tdata[27:23];

	tcw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.item       (item),
		.text_color (text_color_q),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	tcw_ram #(
		.DEPTH  (CELLS),
		.WIDTH  (CELL_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// The output register is free when it is empty or its transfer completes this cycle.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
			m_tdata_q  <= {3'b000, res.cell_value, res.scrolled, res.cursor_col,
					res.cursor_row};
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- tb/text_console_writer_core_test.sv -----
// Self-checking testbench for the text console writer core.
`timescale 1ns / 1ps
// Commands go in on the slave stream and results come back on the master stream. Each
// accepted command is run through a behavioural copy of the console: screen store, cursor
// and colour register. The result it gives is queued, and every result transfer is checked
// against the oldest entry in that queue. The run starts with a few directed commands.
// These are the field extremes, each mode, newline, tab and out-of-range cells. Random
// phases follow under three idling patterns, after a receiver hold-off that backs the block up
// and a newline-heavy stream that keeps the cursor on the bottom row so that it scrolls
// often. The colour register is written between phases, only once every result has arrived.
module text_console_writer_core_test;
	import tcw_pkg::*;

	localparam int CLK_HALF    = 2;
	localparam int RESET_TICKS = 11;
	// A clear or a scroll keeps both streams quiet while it sweeps the screen, and the receiver
	// hold-off can add to that silence, so this is several times the longest correct silence.
	localparam int QUIET_LIMIT = 4 * CELLS + 2000;
	localparam int HOLD_TICKS  = 300;
	localparam int MAX_REPORTS = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;
	logic [1:0]  s_tuser = MODE_PUT_CHAR;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	// Behavioural copy of the console.
	logic [CELL_W-1:0] screen_mem [0:CELLS-1];
	int                cur_r = 0;
	int                cur_c = 0;
	logic [7:0]        text_colour = TEXT_COLOR_RESET;
	bit                screen_defined = 1'b0;

	// Results still owed by the block, oldest first.
	result_t pending_outcomes[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold_left = 0;
	int quiet_cycles = 0;

	int commands_sent = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int reads_sent = 0;
	int clears_sent = 0;
	int scrolls_seen = 0;
	int colours_written = 0;

	text_console_writer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Moves the cursor down one row and scrolls the screen when it runs off the bottom.
	function automatic logic next_console_row();
		int i;
		cur_r++;
		if (cur_r < ROWS)
			return 1'b0;
		cur_r = ROWS - 1;
		for (i = 0; i < CELLS - COLUMNS; i++)
			screen_mem[i] = screen_mem[i + COLUMNS];
		for (i = CELLS - COLUMNS; i < CELLS; i++)
			screen_mem[i] = {text_colour, CODE_SPACE};
		scrolls_seen++;
		return 1'b1;
	endfunction

	// Applies one command to the console copy and returns the result it must produce.
	function automatic result_t console_outcome(input item_t cmd);
		result_t res;
		int      idx;
		int      i;
		logic    on_screen;
		res = '0;
		idx = int'(cmd.cell_row) * COLUMNS + int'(cmd.cell_col);
		on_screen = (int'(cmd.cell_row) < ROWS) && (int'(cmd.cell_col) < COLUMNS);
		case (cmd.mode)
			MODE_PUT_CHAR: begin
				if (cmd.char_code == CODE_NEWLINE) begin
					cur_c = 0;
					res.scrolled = next_console_row();
				end else if (cmd.char_code == CODE_TAB) begin
					cur_c += TAB_ADVANCE + 1;
					if (cur_c >= COLUMNS) begin
						cur_c = TAB_WRAP;
						res.scrolled = next_console_row();
					end
				end else begin
					screen_mem[cur_r * COLUMNS + cur_c] = {text_colour, cmd.char_code};
					cur_c++;
					if (cur_c >= COLUMNS) begin
						cur_c = 0;
						res.scrolled = next_console_row();
					end
				end
			end
			MODE_PUT_CELL: begin
				if (on_screen)
					screen_mem[idx] = {cmd.cell_color, cmd.char_code};
			end
			MODE_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					screen_mem[i] = {text_colour, CODE_SPACE};
				cur_r = 0;
				cur_c = 0;
				screen_defined = 1'b1;
				clears_sent++;
			end
			default: begin
				if (on_screen)
					res.cell_value = screen_mem[idx];
				reads_sent++;
			end
		endcase
		res.cursor_row = ROW_W'(cur_r);
		res.cursor_col = COL_W'(cur_c);
		return res;
	endfunction

	function automatic item_t make_command(input logic [1:0] mode, input logic [7:0] ch,
			input logic [7:0] colour, input int col, input int row);
		item_t cmd;
		cmd.mode       = mode;
		cmd.char_code  = ch;
		cmd.cell_color = colour;
		cmd.cell_col   = COL_W'(col);
		cmd.cell_row   = ROW_W'(row);
		return cmd;
	endfunction

	// Random command. Unused fields are random as well, so every command field bit toggles. Reads
	// favour the cursor row, where recent characters and scrolled-in blanks sit.
	function automatic item_t random_command(input int newline_pct, input int tab_pct,
			input int clear_per_mille);
		item_t cmd;
		int    pick;
		int    aim;
		cmd = make_command(MODE_PUT_CHAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
			$urandom_range(127), $urandom_range(31));
		pick = $urandom_range(999);
		aim  = $urandom_range(99);
		if (pick < clear_per_mille) begin
			cmd.mode = MODE_CLEAR;
		end else if (pick < 600) begin
			if (aim < newline_pct)
				cmd.char_code = CODE_NEWLINE;
			else if (aim < newline_pct + tab_pct)
				cmd.char_code = CODE_TAB;
		end else begin
			cmd.mode = (pick < 760) ? MODE_PUT_CELL : MODE_READ;
			if (aim >= 15) begin
				cmd.cell_col = COL_W'($urandom_range(COLUMNS - 1));
				cmd.cell_row = (aim < 55) ? ROW_W'(cur_r) : ROW_W'($urandom_range(ROWS - 1));
			end
			// Until the first clear the store holds nothing defined, so reads stay off-screen.
			if (cmd.mode == MODE_READ && !screen_defined)
				cmd.cell_row = ROW_W'($urandom_range(31, ROWS));
		end
		return cmd;
	endfunction

	// Offers one command, with random gaps first, and records its result on acceptance.
	task automatic send_command(input item_t cmd);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, cmd.cell_row, cmd.cell_col, cmd.cell_color, cmd.char_code};
		s_tuser  <= cmd.mode;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_outcomes.push_back(console_outcome(cmd));
		commands_sent++;
	endtask

	// Stops offering commands until every owed result has been taken.
	task automatic wait_for_outcomes();
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Only called with nothing outstanding, and never twice without a command in between.
	task automatic write_text_colour(input logic [7:0] colour);
		cfg_valid <= 1'b1;
		cfg_data  <= colour;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		text_colour = colour;
		colours_written++;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] wanted);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns: result %0d, %s mismatch: got 0x%0h, expected 0x%0h",
				$time, results_checked, what, seen, wanted);
	endtask

	// Before any clear: off-screen read, a character, an off-screen cell write, tab, newline.
	task automatic test_before_clear();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_command(make_command(MODE_READ, 8'hFF, 8'hFF, 127, 31));
		send_command(make_command(MODE_PUT_CHAR, 8'h48, 8'h00, 0, 0));
		send_command(make_command(MODE_PUT_CELL, 8'h55, 8'hAA, 127, 0));
		send_command(make_command(MODE_PUT_CHAR, CODE_TAB, 8'hFF, 127, 31));
		send_command(make_command(MODE_PUT_CHAR, CODE_NEWLINE, 8'h00, 0, 0));
	endtask

	// Clear in colour 0, then cell writes and reads at two opposite corners and just off the screen.
	task automatic test_clear_and_cells();
		wait_for_outcomes();
		write_text_colour(8'h00);
		send_command(make_command(MODE_CLEAR, 8'hFF, 8'hFF, 127, 31));
		send_command(make_command(MODE_READ, 8'h00, 8'h00, 0, 0));
		send_command(make_command(MODE_READ, 8'h00, 8'h00, COLUMNS - 1, ROWS - 1));
		send_command(make_command(MODE_PUT_CELL, 8'hFF, 8'hFF, COLUMNS - 1, ROWS - 1));
		send_command(make_command(MODE_READ, 8'hFF, 8'hFF, COLUMNS - 1, ROWS - 1));
		send_command(make_command(MODE_PUT_CELL, 8'h00, 8'h00, 0, 0));
		send_command(make_command(MODE_READ, 8'h00, 8'h00, 0, 0));
		send_command(make_command(MODE_PUT_CELL, 8'h5A, 8'hA5, 0, ROWS));
		send_command(make_command(MODE_READ, 8'h00, 8'h00, 0, ROWS));
		send_command(make_command(MODE_READ, 8'h00, 8'h00, COLUMNS, 0));
	endtask

	// Streamed characters in colour 255, including the byte extremes, newline and two tabs, then reads.
	task automatic test_stream_characters();
		wait_for_outcomes();
		write_text_colour(8'hFF);
		send_command(make_command(MODE_PUT_CHAR, 8'h41, 8'h00, 0, 0));
		send_command(make_command(MODE_PUT_CHAR, 8'h00, 8'h00, 0, 0));
		send_command(make_command(MODE_PUT_CHAR, 8'hFF, 8'hFF, 127, 31));
		send_command(make_command(MODE_PUT_CHAR, CODE_NEWLINE, 8'h00, 0, 0));
		send_command(make_command(MODE_PUT_CHAR, CODE_TAB, 8'h00, 0, 0));
		send_command(make_command(MODE_PUT_CHAR, CODE_TAB, 8'h00, 0, 0));
		send_command(make_command(MODE_READ, 8'h00, 8'h00, 0, 0));
		send_command(make_command(MODE_READ, 8'h00, 8'h00, 2, 0));
		send_command(make_command(MODE_READ, 8'h00, 8'h00, 3, 1));
	endtask

	// The receiver refuses results for a long stretch while commands keep coming, so the
	// output register fills and the block has to hold s_tready low.
	task automatic test_receiver_hold_off();
		int n;
		wait_for_outcomes();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold_left = HOLD_TICKS;
		for (n = 0; n < 12; n++)
			send_command(random_command(5, 10, 0));
		wait_for_outcomes();
	endtask

	// Newline-heavy text pins the cursor to the bottom row, so most row advances scroll.
	task automatic test_bottom_rows(input int count);
		int n;
		wait_for_outcomes();
		write_text_colour(8'($urandom_range(255)));
		send_idle_pct = 17;
		recv_idle_pct = 68;
		for (n = 0; n < count; n++)
			send_command(random_command(45, 10, 0));
	endtask

	task automatic test_random_mix(input int count, input int send_pct, input int recv_pct,
			input logic [7:0] colour);
		int n;
		wait_for_outcomes();
		write_text_colour(colour);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (n = 0; n < count; n++)
			send_command(random_command(2, 10, 4));
	endtask

	// Receiver: random refusals, or a forced hold-off counted down here.
	always @(posedge clk) begin
		if (recv_hold_left > 0) begin
			recv_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Result checker: every result transfer is matched against the oldest owed result.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 32'd0);
			end else begin
				want = pending_outcomes.pop_front();
				if (m_tdata[4:0] !== want.cursor_row)
					report_mismatch("cursor_row", 32'(m_tdata[4:0]), 32'(want.cursor_row));
				if (m_tdata[11:5] !== want.cursor_col)
					report_mismatch("cursor_col", 32'(m_tdata[11:5]), 32'(want.cursor_col));
				if (m_tdata[12] !== want.scrolled)
					report_mismatch("scrolled", 32'(m_tdata[12]), 32'(want.scrolled));
				if (m_tdata[28:13] !== want.cell_value)
					report_mismatch("cell_value", 32'(m_tdata[28:13]), 32'(want.cell_value));
				if (m_tdata[31:29] !== 3'b000)
					report_mismatch("padding", 32'(m_tdata[31:29]), 32'd0);
			end
			results_checked++;
		end
	end

	// Watchdog: ends the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d results still owed",
					quiet_cycles, pending_outcomes.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_clear();
		test_clear_and_cells();
		test_stream_characters();
		test_receiver_hold_off();
		test_bottom_rows(160);
		test_random_mix(380, 17, 68, 8'($urandom_range(1, 254)));
		test_random_mix(380, 68, 17, TEXT_COLOR_RESET);
		test_random_mix(380, 0, 0, 8'($urandom_range(255)));

		wait_for_outcomes();
		// Every result has arrived; the wait that follows catches any stray result transfer.
		repeat (50) @(posedge clk);

		$display("Ran %0d commands: %0d reads, %0d clears, %0d scrolls, %0d colour settings.",
			commands_sent, reads_sent, clears_sent, scrolls_seen, colours_written);
		$display("Checked %0d results field by field, %0d mismatches.",
			results_checked, mismatch_count);
		if (mismatch_count == 0 && pending_outcomes.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_core.sv
tb/text_console_writer_core_test.sv
